### rtl/core/gbc_pkg.sv
package gbc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W = 8;
    localparam int ROW_W = 16;
    localparam int COL_W = 11;
    localparam int WID_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WID_W-1:0] WIDTH_RST = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_RECV,
        PH_FLUSH
    } t_phase;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // decoded work for one transaction, carried into the kernel stage
    typedef struct packed {
        logic             shift;
        logic             emit;
        logic             we_above;
        logic             top_from_above;
        logic             bot_from_px;
        logic [PIX_W-1:0] px;
        logic             col_ge1;
        logic             col_ge2;
        logic             col_end;
        logic             final_row;
        logic [ROW_W-1:0] orow;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } t_result;

    function automatic logic [9:0] f_col_sum(t_column k);
        return 10'(k.top) + 10'({k.mid, 1'b0}) + 10'(k.bot);
    endfunction

    function automatic logic [PIX_W-1:0] f_blur(t_column l, t_column c, t_column r);
        logic [11:0] s;
        s = 12'(f_col_sum(l)) + 12'({f_col_sum(c), 1'b0}) + 12'(f_col_sum(r));
        return s[11:4];
    endfunction

endpackage

### rtl/core/gbc_ctrl.sv
module gbc_ctrl #(
    parameter int MAX_WIDTH = gbc_pkg::MAX_WIDTH_DEF,
    parameter int CW = $clog2(MAX_WIDTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_mode,
    input  logic [gbc_pkg::PIX_W-1:0]      i_pixel_in,
    output gbc_pkg::t_item                 o_item,
    output logic [CW-1:0]                  o_col,
    output logic                           o_mid_we
);
    import gbc_pkg::*;

    logic [WID_W-1:0] r_width,  n_width;
    logic [ROW_W-1:0] r_height, n_height;
    logic [CW-1:0]    r_col,    n_col;
    logic [ROW_W-1:0] r_row,    n_row;
    t_phase           r_phase,  n_phase;

    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic             col_end;
    logic             row_end;
    logic             is_pix;
    logic             is_flush;
    logic             row_ge1;
    logic             row_ge2;
    logic             cfg_hit;

    always_comb begin
        if (r_width == '0) begin
            w_last = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - 1'b1);
        end
        h_last = (r_height == '0) ? '0 : r_height - 1'b1;
    end

    assign col_end  = (r_col == w_last);
    assign row_end  = (r_row == h_last);
    assign is_pix   = !i_mode && (r_phase != PH_FLUSH);
    assign is_flush = i_mode && (r_phase == PH_FLUSH);
    assign row_ge1  = (r_row != '0);
    assign row_ge2  = (r_row > ROW_W'(1));

    always_comb begin
        o_item.shift          = is_pix || is_flush;
        o_item.emit           = is_flush || (is_pix && row_ge1);
        o_item.we_above       = is_pix && row_ge1;
        o_item.top_from_above = is_pix ? row_ge2 : row_ge1;
        o_item.bot_from_px    = is_pix;
        o_item.px             = i_pixel_in;
        o_item.col_ge1        = (r_col != '0);
        o_item.col_ge2        = (32'(r_col) >= 2);
        o_item.col_end        = col_end;
        o_item.final_row      = is_flush;
        o_item.orow           = is_pix ? r_row - 1'b1 : r_row;
    end

    assign o_col    = r_col;
    assign o_mid_we = i_accept && is_pix;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_phase  = r_phase;
        cfg_hit  = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_width = i_cfg_data[WID_W-1:0];
                    cfg_hit = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = i_cfg_data[ROW_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit) begin
            // abort the frame in progress
            n_col   = '0;
            n_row   = '0;
            n_phase = PH_WAIT;
        end else if (i_accept && is_pix) begin
            n_phase = PH_RECV;
            if (col_end) begin
                n_col = '0;
                if (row_end) begin
                    n_phase = PH_FLUSH;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end else if (i_accept && is_flush) begin
            if (col_end) begin
                n_col   = '0;
                n_row   = '0;
                n_phase = PH_WAIT;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_phase  <= PH_WAIT;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_phase  <= n_phase;
        end
    end

endmodule

### rtl/core/gbc_line_store.sv
module gbc_line_store #(
    parameter int MAX_WIDTH = gbc_pkg::MAX_WIDTH_DEF,
    parameter int CW = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [CW-1:0]             i_addr,
    input  logic                      i_mid_we,
    input  logic [gbc_pkg::PIX_W-1:0] i_px,
    input  logic                      i_above_we,
    input  logic [CW-1:0]             i_above_addr,
    input  logic [gbc_pkg::PIX_W-1:0] i_above_data,
    output logic [gbc_pkg::PIX_W-1:0] o_mid,
    output logic [gbc_pkg::PIX_W-1:0] o_above
);
    import gbc_pkg::*;

    logic [PIX_W-1:0] mem_mid   [MAX_WIDTH];
    logic [PIX_W-1:0] mem_above [MAX_WIDTH];

    logic [PIX_W-1:0] r_mid;
    logic [PIX_W-1:0] r_above;
    logic [PIX_W-1:0] r_fwd_data;
    logic             r_fwd;

    // read-first: the pixel written here is seen by the next read only
    always_ff @(posedge i_clk) begin
        if (i_mid_we) begin
            mem_mid[i_addr] <= i_px;
        end
        if (i_rd_en) begin
            r_mid <= mem_mid[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_above_we) begin
            mem_above[i_above_addr] <= i_above_data;
        end
        if (i_rd_en) begin
            r_above    <= mem_above[i_addr];
            r_fwd_data <= i_above_data;
        end
    end

    // a write landing on the entry being read in the same cycle is bypassed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_above_we && (i_above_addr == i_addr);
        end
    end

    assign o_mid   = r_mid;
    assign o_above = r_fwd ? r_fwd_data : r_above;

endmodule

### rtl/core/gbc_window.sv
module gbc_window #(
    parameter int MAX_WIDTH = gbc_pkg::MAX_WIDTH_DEF,
    parameter int CW = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  gbc_pkg::t_item            i_item,
    input  logic [CW-1:0]             i_col,
    input  logic [gbc_pkg::PIX_W-1:0] i_mid,
    input  logic [gbc_pkg::PIX_W-1:0] i_above,
    output logic                      o_free,
    output logic                      o_above_we,
    output logic [CW-1:0]             o_above_addr,
    output logic [gbc_pkg::PIX_W-1:0] o_above_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output gbc_pkg::t_result          o_result
);
    import gbc_pkg::*;

    localparam int XW = (CW > COL_W) ? CW : COL_W;

    logic          r_s1_vld;
    t_item         r_s1;
    logic [CW-1:0] r_s1_col;

    t_column r_win [3];
    t_column nw0, nw1, nw2;

    t_result r_slot [2];
    t_result n_slot [2];
    logic [1:0] r_cnt, n_cnt;

    t_result  res_a, res_b, first_res;
    logic     has_a, has_b;
    logic [1:0] n_res;
    logic [1:0] kept;
    logic     pop;
    logic     adv;
    logic [XW-1:0] col_x, colm1_x;

    // window after this transaction's shift
    always_comb begin
        nw0     = r_win[1];
        nw1     = r_win[2];
        nw2.top = r_s1.top_from_above ? i_above : i_mid;
        nw2.mid = i_mid;
        nw2.bot = r_s1.bot_from_px ? r_s1.px : i_mid;
    end

    assign col_x   = XW'(r_s1_col);
    assign colm1_x = XW'(r_s1_col - 1'b1);

    assign has_a = r_s1.emit && r_s1.col_ge1;
    assign has_b = r_s1.emit && r_s1.col_end;
    assign n_res = {1'b0, has_a} + {1'b0, has_b};

    always_comb begin
        res_a.pixel = f_blur(r_s1.col_ge2 ? nw0 : nw1, nw1, nw2);
        res_a.row   = r_s1.orow;
        res_a.col   = colm1_x[COL_W-1:0];
        res_a.last  = !has_b;
        res_a.done  = 1'b0;

        res_b.pixel = f_blur(r_s1.col_ge1 ? nw1 : nw2, nw2, nw2);
        res_b.row   = r_s1.orow;
        res_b.col   = col_x[COL_W-1:0];
        res_b.last  = 1'b1;
        res_b.done  = r_s1.final_row;

        first_res = has_a ? res_a : res_b;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_result    = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    assign kept        = pop ? r_cnt - 2'd1 : r_cnt;
    assign adv         = r_s1_vld && ((3'(kept) + 3'(n_res)) <= 3'd2);
    assign o_free      = !r_s1_vld || adv;

    assign o_above_we   = adv && r_s1.we_above;
    assign o_above_addr = r_s1_col;
    assign o_above_data = i_mid;

    always_comb begin
        n_slot[0] = pop ? r_slot[1] : r_slot[0];
        n_slot[1] = r_slot[1];
        n_cnt     = kept;
        if (adv && (n_res != 2'd0)) begin
            if (kept == 2'd0) begin
                n_slot[0] = first_res;
                n_slot[1] = res_b;
            end else begin
                n_slot[1] = first_res;
            end
            n_cnt = kept + n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
        if (i_accept) begin
            r_s1     <= i_item;
            r_s1_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_cnt    <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (i_accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv && r_s1.shift) begin
                r_win[0] <= nw0;
                r_win[1] <= nw1;
                r_win[2] <= nw2;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv) |-> (r_cnt != 2'd0))
        else $error("kernel stage stalled with empty result buffer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv) |=> r_s1_vld)
        else $error("stalled transaction lost from kernel stage");

    a_pop_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_cnt == 2'd2)) |=> o_out_valid)
        else $error("second buffered result dropped");
`endif

endmodule

### rtl/core/gaussian_blur_3x3_clamped.sv
// A result passes the kernel stage register and a two-entry result buffer before it is
// offered. Throughput: one input transaction per cycle while the buffer has room; a row-end
// pixel or flush tick can give two results, which leave one per cycle while i_out_ready is
// high. Reset (i_rst_n low at a clock edge): width 640, height 480, counters and window
// cleared, buffers emptied; line stores are not cleared and are only used once written.
module gaussian_blur_3x3_clamped #(
    parameter int MAX_WIDTH = gbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [gbc_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gbc_pkg::PIX_W-1:0]      o_pixel_out,
    output logic [gbc_pkg::ROW_W-1:0]      o_out_row,
    output logic [gbc_pkg::COL_W-1:0]      o_out_col,
    output logic                           o_last_in_run,
    output logic                           o_frame_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gbc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic             accept;
    t_item            item;
    logic [CW-1:0]    col;
    logic             mid_we;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] above_rd;
    logic             above_we;
    logic [CW-1:0]    above_addr;
    logic [PIX_W-1:0] above_data;
    t_result          result;

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    gbc_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_pixel_in  (i_pixel_in),
        .o_item      (item),
        .o_col       (col),
        .o_mid_we    (mid_we)
    );

    gbc_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_addr       (col),
        .i_mid_we     (mid_we),
        .i_px         (i_pixel_in),
        .i_above_we   (above_we),
        .i_above_addr (above_addr),
        .i_above_data (above_data),
        .o_mid        (mid_rd),
        .o_above      (above_rd)
    );

    gbc_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (item),
        .i_col        (col),
        .i_mid        (mid_rd),
        .i_above      (above_rd),
        .o_free       (o_in_ready),
        .o_above_we   (above_we),
        .o_above_addr (above_addr),
        .o_above_data (above_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_pixel_out   = result.pixel;
    assign o_out_row     = result.row;
    assign o_out_col     = result.col;
    assign o_last_in_run = result.last;
    assign o_frame_done  = result.done;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import gbc_pkg::*;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam int   STORE_DEPTH = MAX_WIDTH_DEF;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] px;
    } t_stream_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = MODE_PIXEL;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic                  o_last_in_run;
    logic                  o_frame_done;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gaussian_blur_3x3_clamped dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_in    (i_pixel_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_in_run (o_last_in_run),
        .o_frame_done  (o_frame_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pending pixels and flush ticks, and blurred pixels still owed by the block
    t_stream_item stream_q [$];
    t_result      blurred_q [$];
    t_stream_item next_item;
    t_result      want_res;

    int unsigned pushed_n = 0;
    int unsigned accepted_n = 0;
    int unsigned fail_count = 0;
    bit          in_taken = 1'b0;
    bit          cfg_taken = 1'b0;
    bit          calm = 1'b0;

    // shadow of the block's state
    logic [WID_W-1:0] cur_width;
    logic [ROW_W-1:0] cur_height;
    logic [PIX_W-1:0] above_row [STORE_DEPTH];
    logic [PIX_W-1:0] middle_row [STORE_DEPTH];
    t_column          win [3];
    int unsigned      col_at;
    int unsigned      row_at;
    t_phase           phase_at;

    function automatic logic [PIX_W-1:0] kernel_avg(t_column l, t_column m, t_column r);
        int unsigned sl, sm, sr;
        sl = 32'(l.top) + 2 * 32'(l.mid) + 32'(l.bot);
        sm = 32'(m.top) + 2 * 32'(m.mid) + 32'(m.bot);
        sr = 32'(r.top) + 2 * 32'(r.mid) + 32'(r.bot);
        return 8'((sl + 2 * sm + sr) / 16);
    endfunction

    task automatic slide_window(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m, logic [PIX_W-1:0] b);
        win[0] = win[1];
        win[1] = win[2];
        win[2].top = t;
        win[2].mid = m;
        win[2].bot = b;
    endtask

    // results of output row orow for input column c: the column behind, and the row end
    task automatic emit_blur(int unsigned orow, int unsigned c, int unsigned w, logic fin);
        t_result res [2];
        int      n;
        n = 0;
        if (c >= 1) begin
            res[n].pixel = kernel_avg((c >= 2) ? win[0] : win[1], win[1], win[2]);
            res[n].row   = ROW_W'(orow);
            res[n].col   = COL_W'(c - 1);
            res[n].last  = 1'b0;
            res[n].done  = 1'b0;
            n++;
        end
        if (c == w - 1) begin
            res[n].pixel = kernel_avg((c >= 1) ? win[1] : win[2], win[2], win[2]);
            res[n].row   = ROW_W'(orow);
            res[n].col   = COL_W'(c);
            res[n].last  = 1'b0;
            res[n].done  = fin;
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) blurred_q.push_back(res[i]);
    endtask

    task automatic blur_predict(logic mode, logic [PIX_W-1:0] px);
        int unsigned      w, h, c, r;
        logic [PIX_W-1:0] mid, top;
        w = (cur_width == 0) ? 1 : ((cur_width > STORE_DEPTH) ? STORE_DEPTH : cur_width);
        h = (cur_height == 0) ? 1 : cur_height;
        c = (col_at >= w) ? w - 1 : col_at;
        r = (row_at >= h) ? h - 1 : row_at;
        if (mode == MODE_PIXEL) begin
            if (phase_at != PH_FLUSH) begin
                mid = middle_row[c];
                top = (r >= 2) ? above_row[c] : mid;
                slide_window(top, mid, px);
                if (r >= 1) begin
                    above_row[c] = mid;
                    emit_blur(r - 1, c, w, 1'b0);
                end
                middle_row[c] = px;
                phase_at = PH_RECV;
                if (c + 1 >= w) begin
                    col_at = 0;
                    if (r + 1 >= h) begin
                        row_at   = r;
                        phase_at = PH_FLUSH;
                    end else begin
                        row_at = r + 1;
                    end
                end else begin
                    col_at = c + 1;
                    row_at = r;
                end
            end
        end else if (phase_at == PH_FLUSH) begin
            // replay the last row as the clamped row below
            mid = middle_row[c];
            top = (r >= 1) ? above_row[c] : mid;
            slide_window(top, mid, mid);
            emit_blur(r, c, w, 1'b1);
            if (c + 1 >= w) begin
                col_at   = 0;
                row_at   = 0;
                phase_at = PH_WAIT;
            end else begin
                col_at = c + 1;
                row_at = r;
            end
        end
    endtask

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin
        in_taken  = 1'b0;
        cfg_taken = 1'b0;
        if (!i_rst_n) begin
            cur_width  = WIDTH_RST;
            cur_height = HEIGHT_RST;
            for (int i = 0; i < 3; i++) win[i] = '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                above_row[i]  = '0;
                middle_row[i] = '0;
            end
            col_at   = 0;
            row_at   = 0;
            phase_at = PH_WAIT;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("unexpected result: row %0d col %0d pixel %0d",
                           o_out_row, o_out_col, o_pixel_out);
                    fail_count++;
                end else begin
                    want_res = blurred_q.pop_front();
                    if (o_pixel_out !== want_res.pixel) begin
                        $error("pixel_out: expected %0d, got %0d", want_res.pixel, o_pixel_out);
                        fail_count++;
                    end
                    if (o_out_row !== want_res.row) begin
                        $error("out_row: expected %0d, got %0d", want_res.row, o_out_row);
                        fail_count++;
                    end
                    if (o_out_col !== want_res.col) begin
                        $error("out_col: expected %0d, got %0d", want_res.col, o_out_col);
                        fail_count++;
                    end
                    if (o_last_in_run !== want_res.last) begin
                        $error("last_in_run: expected %0d, got %0d", want_res.last,
                               o_last_in_run);
                        fail_count++;
                    end
                    if (o_frame_done !== want_res.done) begin
                        $error("frame_done: expected %0d, got %0d", want_res.done,
                               o_frame_done);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                blur_predict(i_mode, i_pixel_in);
                accepted_n++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_taken = 1'b1;
                if (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT) begin
                    if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                        cur_width = i_cfg_data[WID_W-1:0];
                    end else begin
                        cur_height = i_cfg_data;
                    end
                    // a register write aborts the frame in progress
                    col_at   = 0;
                    row_at   = 0;
                    phase_at = PH_WAIT;
                end
            end
        end
    end

    // driver: advance on the falling edge once the previous transaction has gone
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (stream_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
                next_item = stream_q.pop_front();
                i_in_valid <= 1'b1;
                i_mode     <= next_item.mode;
                i_pixel_in <= next_item.px;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= calm || ($urandom_range(99) >= 10);
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic send(logic mode, logic [PIX_W-1:0] px);
        stream_q.push_back({mode, px});
        pushed_n++;
    endtask

    // wait until every transaction is in and every result is out, then let the pipe empty
    task automatic drain();
        do @(negedge i_clk);
        while (accepted_n != pushed_n || blurred_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // one frame of w x h pixels and w flush ticks, stopped early at cut; sprinkle ignored flush ticks and pixels
    task automatic send_frame(int unsigned w, int unsigned h, int unsigned cut,
                              output int unsigned sent);
        int unsigned k;
        sent = 0;
        for (k = 0; k < w * h + w && k < cut; k++) begin
            if ($urandom_range(99) < 3) send((k < w * h) ? MODE_FLUSH : MODE_PIXEL, rand_pixel());
            send((k < w * h) ? MODE_PIXEL : MODE_FLUSH, rand_pixel());
            sent++;
        end
    endtask

    initial begin
        logic [PIX_W-1:0] grid [9];
        int unsigned      n_sent, useful_n, fw, fh, total, cut;
        bit               dirty;

        grid = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // flush tick with no frame open, then pixels under the reset geometry
        send(MODE_FLUSH, 8'h00);
        send(MODE_PIXEL, 8'hFF);
        send(MODE_PIXEL, 8'h00);
        send(MODE_PIXEL, 8'hFF);

        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++) begin
            send(MODE_PIXEL, grid[i]);
            if (i == 2) send(MODE_FLUSH, 8'hFF);
        end
        send(MODE_PIXEL, 8'h12);
        repeat (3) send(MODE_FLUSH, 8'hFF);

        // width zero with junk in the upper bits, height zero: both act as one
        write_reg(CFG_IMAGE_WIDTH, 16'hF000);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        send(MODE_PIXEL, 8'hA5);
        send(MODE_FLUSH, 8'h5A);

        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'd4);
        send_frame(1, 4, 5, n_sent);

        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        send_frame(2, 1, 4, n_sent);

        // oversized width clamps to the full line store: open a row of that width
        write_reg(CFG_IMAGE_WIDTH, 16'd4095);
        send_frame(STORE_DEPTH, 1, 40, n_sent);

        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (6) send(MODE_PIXEL, rand_pixel());
        dirty = 1'b1;

        useful_n = 0;
        calm     = 1'b1;
        while (useful_n < 780) begin
            if (useful_n > 300) calm = 1'b0;
            if (dirty || $urandom_range(3) != 0) begin
                fw = ($urandom_range(7) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
                if ($urandom_range(19) == 0) fw = 0;
                fh = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
                if ($urandom_range(1)) begin
                    write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(fw)});
                    write_reg(CFG_IMAGE_HEIGHT, 16'(fh));
                end else begin
                    write_reg(CFG_IMAGE_HEIGHT, 16'(fh));
                    write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(fw)});
                end
                if (fw == 0) fw = 1;
                if (fh == 0) fh = 1;
            end
            total = fw * fh + fw;
            cut   = ($urandom_range(99) < 12) ? $urandom_range(total - 1, 1) : total;
            dirty = (cut < total);
            send_frame(fw, fh, cut, n_sent);
            useful_n += n_sent;
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("gaussian_blur_3x3_clamped regression: pass");
        end else begin
            $display("gaussian_blur_3x3_clamped regression: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("gaussian_blur_3x3_clamped regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gbc_pkg.sv
rtl/core/gbc_ctrl.sv
rtl/core/gbc_line_store.sv
rtl/core/gbc_window.sv
rtl/core/gaussian_blur_3x3_clamped.sv
tb/sv/testbench.sv
